>>> design/plasma_pixel_generator_macros.svh
// ---------------------------------------------------------------------------
// Plasma pixel generator assertion macros
// Property shorthands for the generator's checks. Each expects clk and
// rst_n in scope and stays off while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef PLASMA_PIXEL_GENERATOR_MACROS_SVH
`define PLASMA_PIXEL_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PPG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold after the antecedent, delayed by dly
`define PPG_ASSERT_DLY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

>>> design/ppg_pkg.sv
// ---------------------------------------------------------------------------
// Plasma pixel generator package
// Shared widths, constants, sine operand type and register indexes.
// ---------------------------------------------------------------------------
package ppg_pkg;

  // Field widths
  localparam int COORD_W   = 12;
  localparam int RATE_W    = 12;
  localparam int LEVEL_W   = 8;
  localparam int PACKED_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Phase resolution default (bits per turn)
  localparam int PHASE_BITS_DEF = 12;

  // Cycles from request acceptance to result strobe sample
  localparam int OUT_LATENCY = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RATE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_RATE = 2'd2;

  // Configuration reset values
  localparam logic [RATE_W-1:0] X_RATE_RST    = 12'd65;
  localparam logic [RATE_W-1:0] Y_RATE_RST    = 12'd98;
  localparam logic [RATE_W-1:0] DIAG_RATE_RST = 12'd65;

  // Sine polynomial coefficients, Q14
  localparam logic [14:0] SIN_ONE = 15'd16384;
  localparam logic [14:0] SIN_A   = 15'd25736;
  localparam logic [13:0] SIN_B   = 14'd10512;
  localparam logic [10:0] SIN_C   = 11'd1160;

  // Quarter-wave operand: folded angle in Q14 and the sign of the result
  typedef struct packed {
    logic        neg;
    logic [14:0] z;
  } sine_arg_t;

  // Signed Q1.14 sine value
  typedef logic signed [15:0] sine_val_t;

endpackage

>>> design/ppg_phase.sv
// ---------------------------------------------------------------------------
// Plasma phase stage
// Forms the three wave phases and folds each into a quarter-wave operand.
// ---------------------------------------------------------------------------
module ppg_phase
  import ppg_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic              clk,
  input  logic [COORD_W-1:0] pixel_x,
  input  logic [COORD_W-1:0] pixel_y,
  input  logic [COORD_W-1:0] time_phase,
  input  logic [RATE_W-1:0]  x_rate,
  input  logic [RATE_W-1:0]  y_rate,
  input  logic [RATE_W-1:0]  diag_rate,
  output sine_arg_t          arg_x,
  output sine_arg_t          arg_y,
  output sine_arg_t          arg_d
);

  // Wrap the raw phase to one turn, scale to 16 bits and fold the quadrant
  function automatic sine_arg_t to_arg(input logic [25:0] raw);
    logic [15:0] u;
    sine_arg_t   a;
    u     = 16'(raw[PHASE_BITS-1:0]) << (16 - PHASE_BITS);
    a.neg = u[15];
    a.z   = u[14] ? (SIN_ONE - {1'b0, u[13:0]}) : {1'b0, u[13:0]};
    return a;
  endfunction

  logic [23:0]        prod_x;
  logic [23:0]        prod_y;
  logic [12:0]        xy_sum;
  logic [24:0]        prod_d;
  logic [25:0]        raw_x;
  logic [25:0]        raw_y;
  logic [25:0]        raw_d;
  sine_arg_t          arg_x_r;
  sine_arg_t          arg_y_r;
  sine_arg_t          arg_d_r;

  // Scale coordinates by their phase rates and add time
  assign prod_x = pixel_x * x_rate;
  assign prod_y = pixel_y * y_rate;
  assign xy_sum = {1'b0, pixel_x} + {1'b0, pixel_y};
  assign prod_d = xy_sum * diag_rate;
  assign raw_x  = 26'(prod_x) + 26'(time_phase);
  assign raw_y  = 26'(prod_y) + 26'(time_phase);
  assign raw_d  = 26'(prod_d) + 26'(time_phase);

  // Hold the folded operands for the sine pipeline
  always_ff @(posedge clk) begin
    arg_x_r <= to_arg(raw_x);
    arg_y_r <= to_arg(raw_y);
    arg_d_r <= to_arg(raw_d);
  end

  assign arg_x = arg_x_r;
  assign arg_y = arg_y_r;
  assign arg_d = arg_d_r;

endmodule

>>> design/ppg_sine.sv
// ---------------------------------------------------------------------------
// Plasma sine pipeline
// Fifth-order odd polynomial over a quarter wave, one multiply per stage.
// ---------------------------------------------------------------------------
module ppg_sine
  import ppg_pkg::*;
(
  input  logic      clk,
  input  sine_arg_t arg,
  output sine_val_t sine
);

  logic [29:0] zz;
  logic [14:0] z2_r;
  sine_arg_t   arg2_r;
  logic [25:0] pc;
  logic [13:0] inner_r;
  logic [14:0] z23_r;
  sine_arg_t   arg3_r;
  logic [28:0] pm;
  logic [14:0] mid_r;
  sine_arg_t   arg4_r;
  logic [29:0] ps;
  logic [15:0] mag;
  sine_val_t   sine_r;

  // Square the folded angle
  assign zz = arg.z * arg.z;

  always_ff @(posedge clk) begin
    z2_r   <= zz[28:14];
    arg2_r <= arg;
  end

  // Innermost coefficient term
  assign pc = z2_r * SIN_C;

  always_ff @(posedge clk) begin
    inner_r <= SIN_B - 14'(pc[24:14]);
    z23_r   <= z2_r;
    arg3_r  <= arg2_r;
  end

  // Middle coefficient term
  assign pm = z23_r * inner_r;

  always_ff @(posedge clk) begin
    mid_r  <= SIN_A - 15'(pm[27:14]);
    arg4_r <= arg3_r;
  end

  // Final product and quadrant sign
  assign ps  = arg4_r.z * mid_r;
  assign mag = {1'b0, ps[28:14]};

  always_ff @(posedge clk) begin
    sine_r <= arg4_r.neg ? -$signed(mag) : $signed(mag);
  end

  assign sine = sine_r;

endmodule

>>> design/ppg_color.sv
// ---------------------------------------------------------------------------
// Plasma colour stage
// Sums the three sines into a hue and maps it to RGB888 and RGB565.
// ---------------------------------------------------------------------------
module ppg_color
  import ppg_pkg::*;
(
  input  logic               clk,
  input  sine_val_t          sine_x,
  input  sine_val_t          sine_y,
  input  sine_val_t          sine_d,
  output logic [LEVEL_W-1:0] red,
  output logic [LEVEL_W-1:0] green,
  output logic [LEVEL_W-1:0] blue,
  output logic [PACKED_W-1:0] packed_rgb
);

  // Hue sectors
  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;

  localparam logic signed [17:0] SUM_BIAS = 18'sd49152;

  logic signed [17:0] sum3;
  logic signed [17:0] biased;
  logic [22:0]        scaled;
  logic [8:0]         hue_r;
  logic [10:0]        h6;
  logic [2:0]         sector;
  logic [7:0]         frac;
  logic [15:0]        up_full;
  logic [8:0]         rem;
  logic [15:0]        dn_full;
  logic [7:0]         up;
  logic [7:0]         down;
  logic [7:0]         r_nxt;
  logic [7:0]         g_nxt;
  logic [7:0]         b_nxt;
  logic [7:0]         red_r;
  logic [7:0]         green_r;
  logic [7:0]         blue_r;
  logic [15:0]        packed_r;

  // Intensity = ((S + 3.0) * 56) in Q14, range 0..336
  assign sum3   = 18'(sine_x) + 18'(sine_y) + 18'(sine_d);
  assign biased = sum3 + SUM_BIAS;
  assign scaled = biased[16:0] * 6'd56;

  always_ff @(posedge clk) begin
    hue_r <= scaled[22:14];
  end

  // Split hue into sector and fraction
  assign h6      = hue_r[7:0] * 3'd6;
  assign sector  = h6[10:8];
  assign frac    = h6[7:0];
  assign up_full = {frac, 8'd0} - 16'(frac);
  assign rem     = 9'd256 - {1'b0, frac};
  assign dn_full = rem * 8'd255;
  assign up      = up_full[15:8];
  assign down    = dn_full[15:8];

  // Select channel levels
  always_comb begin
    r_nxt = 8'd255;
    g_nxt = 8'd0;
    b_nxt = 8'd0;
    if (!hue_r[8]) begin
      case (sector)
        SEC_RED_YEL: begin
          r_nxt = 8'd255; g_nxt = up;     b_nxt = 8'd0;
        end
        SEC_YEL_GRN: begin
          r_nxt = down;   g_nxt = 8'd255; b_nxt = 8'd0;
        end
        SEC_GRN_CYN: begin
          r_nxt = 8'd0;   g_nxt = 8'd255; b_nxt = up;
        end
        SEC_CYN_BLU: begin
          r_nxt = 8'd0;   g_nxt = down;   b_nxt = 8'd255;
        end
        SEC_BLU_MAG: begin
          r_nxt = up;     g_nxt = 8'd0;   b_nxt = 8'd255;
        end
        default: begin
          r_nxt = 8'd255; g_nxt = 8'd0;   b_nxt = down;
        end
      endcase
    end
  end

  // Hold result levels and the 565 packing
  always_ff @(posedge clk) begin
    red_r    <= r_nxt;
    green_r  <= g_nxt;
    blue_r   <= b_nxt;
    packed_r <= {r_nxt[7:3], g_nxt[7:2], b_nxt[7:3]};
  end

  assign red        = red_r;
  assign green      = green_r;
  assign blue       = blue_r;
  assign packed_rgb = packed_r;

endmodule

>>> design/plasma_pixel_generator.sv
// ---------------------------------------------------------------------------
// Plasma pixel generator
// Sine plasma colour for one pixel coordinate and time phase per clock.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_pixel_x, in_pixel_y and in_time_phase with
//   start high; the request is taken when busy is low. busy stays low, so
//   a request may be issued on every clock.
//   Result channel: out_valid strobes for one cycle with the colour levels
//   and the RGB565 word. The receiver cannot stall; it must take each
//   result in the cycle it is shown.
//   The result passes through the eight-stage pipeline: input register,
//   phase fold, four sine multiply stages, intensity sum and colour map.
//   Throughput is one pixel per clock.
//   Configuration: cfg_wr_en writes cfg_data into the rate register picked
//   by cfg_index; an index past the last register is ignored. Write only
//   while no request is in flight.
//   Reset (synchronous, rst_n low) restores the default rates and drops
//   every request still in the pipeline.
// ---------------------------------------------------------------------------
`include "plasma_pixel_generator_macros.svh"

module plasma_pixel_generator
  import ppg_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [COORD_W-1:0]   in_pixel_x,
  input  logic [COORD_W-1:0]   in_pixel_y,
  input  logic [COORD_W-1:0]   in_time_phase,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data,
  output logic                 out_valid,
  output logic [LEVEL_W-1:0]   out_red_level,
  output logic [LEVEL_W-1:0]   out_green_level,
  output logic [LEVEL_W-1:0]   out_blue_level,
  output logic [PACKED_W-1:0]  out_packed_565
);

  logic                      accept;
  logic [COORD_W-1:0]        x_r;
  logic [COORD_W-1:0]        y_r;
  logic [COORD_W-1:0]        t_r;
  logic [RATE_W-1:0]         x_rate_r;
  logic [RATE_W-1:0]         y_rate_r;
  logic [RATE_W-1:0]         diag_rate_r;
  logic [OUT_LATENCY-1:0]    vld_r;
  logic [OUT_LATENCY-1:0]    vld_nxt;
  sine_arg_t                 arg_x;
  sine_arg_t                 arg_y;
  sine_arg_t                 arg_d;
  sine_val_t                 sine_x;
  sine_val_t                 sine_y;
  sine_val_t                 sine_d;

  // Fully pipelined: never hold off a request
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Rate registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_rate_r    <= X_RATE_RST;
      y_rate_r    <= Y_RATE_RST;
      diag_rate_r <= DIAG_RATE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_X_RATE:    x_rate_r    <= cfg_data;
        CFG_Y_RATE:    y_rate_r    <= cfg_data;
        CFG_DIAG_RATE: diag_rate_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_pixel_x;
      y_r <= in_pixel_y;
      t_r <= in_time_phase;
    end
  end

  // Advance the valid marks alongside the data
  assign vld_nxt = {vld_r[OUT_LATENCY-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[OUT_LATENCY-1];

  ppg_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk        (clk),
    .pixel_x    (x_r),
    .pixel_y    (y_r),
    .time_phase (t_r),
    .x_rate     (x_rate_r),
    .y_rate     (y_rate_r),
    .diag_rate  (diag_rate_r),
    .arg_x      (arg_x),
    .arg_y      (arg_y),
    .arg_d      (arg_d)
  );

  ppg_sine u_sine_x (.clk(clk), .arg(arg_x), .sine(sine_x));
  ppg_sine u_sine_y (.clk(clk), .arg(arg_y), .sine(sine_y));
  ppg_sine u_sine_d (.clk(clk), .arg(arg_d), .sine(sine_d));

  ppg_color u_color (
    .clk        (clk),
    .sine_x     (sine_x),
    .sine_y     (sine_y),
    .sine_d     (sine_d),
    .red        (out_red_level),
    .green      (out_green_level),
    .blue       (out_blue_level),
    .packed_rgb (out_packed_565)
  );

  // Every request yields one result after the pipeline depth
  `PPG_ASSERT_DLY(a_req_to_result, accept, OUT_LATENCY, out_valid, "request produced no result")

  // No result without a matching request
  `PPG_ASSERT_IMP(a_result_has_req, out_valid, $past(accept, OUT_LATENCY), "result without request")

  // A hue colour always has one full and one empty channel
  `PPG_ASSERT_IMP(a_hue_extremes, out_valid,
    (out_red_level == 8'd255 || out_green_level == 8'd255 || out_blue_level == 8'd255) &&
    (out_red_level == 8'd0 || out_green_level == 8'd0 || out_blue_level == 8'd0),
    "colour is not a saturated hue")

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Plasma pixel generator testbench
// Sends pixel requests, predicts the colour of each one in the testbench
// and compares every strobed result against the oldest pending prediction.
// Rate registers are changed between phases once all results are back.
// ---------------------------------------------------------------------------
module tb
  import ppg_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 500;
  localparam int PHASES = 10;
  localparam int PHASE_PIXELS = 64;

  typedef struct {
    logic [LEVEL_W-1:0]  red;
    logic [LEVEL_W-1:0]  green;
    logic [LEVEL_W-1:0]  blue;
    logic [PACKED_W-1:0] rgb565;
  } pixel_color_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [COORD_W-1:0]   in_pixel_x = '0;
  logic [COORD_W-1:0]   in_pixel_y = '0;
  logic [COORD_W-1:0]   in_time_phase = '0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RATE_W-1:0]    cfg_data = '0;
  logic                 out_valid;
  logic [LEVEL_W-1:0]   out_red_level;
  logic [LEVEL_W-1:0]   out_green_level;
  logic [LEVEL_W-1:0]   out_blue_level;
  logic [PACKED_W-1:0]  out_packed_565;

  // Testbench copy of the rate registers
  logic [RATE_W-1:0] x_rate = X_RATE_RST;
  logic [RATE_W-1:0] y_rate = Y_RATE_RST;
  logic [RATE_W-1:0] diag_rate = DIAG_RATE_RST;

  pixel_color_t pending_colors[$];
  int           mismatch_count = 0;
  int           stall_cycles = 0;
  bit           sender_idles = 1'b0;

  plasma_pixel_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_time_phase   (in_time_phase),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_packed_565  (out_packed_565)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Quarter-wave polynomial sine, Q1.14, phase wraps at one turn
  function automatic sine_val_t sine_q14(input int unsigned phase);
    int unsigned u, z, z2, inner, mid, s;
    u = ((phase & ((1 << PHASE_BITS_DEF) - 1)) << (16 - PHASE_BITS_DEF)) & 16'hFFFF;
    z = u & 16'h3FFF;
    if (u[14]) begin
      z = 16384 - z;
    end
    z2 = (z * z) >> 14;
    inner = int'(SIN_B) - ((z2 * int'(SIN_C)) >> 14);
    mid = int'(SIN_A) - ((z2 * inner) >> 14);
    s = (z * mid) >> 14;
    return u[15] ? -sine_val_t'(s) : sine_val_t'(s);
  endfunction

  // Sum of three sines, mapped to a hue and then to RGB
  function automatic pixel_color_t plasma_color(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [COORD_W-1:0] t);
    int           sum;
    int unsigned  xi, yi, ti, hue, h6, k, up, down;
    pixel_color_t c;
    xi = x;
    yi = y;
    ti = t;
    sum = int'(sine_q14(xi * x_rate + ti)) + int'(sine_q14(yi * y_rate + ti))
        + int'(sine_q14((xi + yi) * diag_rate + ti));
    hue = ((sum + 49152) * 56) >> 14;
    h6 = hue * 6;
    k = h6 & 255;
    up = (k * 255) >> 8;
    down = ((256 - k) * 255) >> 8;
    if (hue >= 256) begin
      c.red = 8'd255; c.green = 8'd0; c.blue = 8'd0;
    end else begin
      case (h6 >> 8)
        0: begin c.red = 8'd255;   c.green = 8'(up);   c.blue = 8'd0;   end
        1: begin c.red = 8'(down); c.green = 8'd255;   c.blue = 8'd0;   end
        2: begin c.red = 8'd0;     c.green = 8'd255;   c.blue = 8'(up); end
        3: begin c.red = 8'd0;     c.green = 8'(down); c.blue = 8'd255; end
        4: begin c.red = 8'(up);   c.green = 8'd0;     c.blue = 8'd255; end
        default: begin c.red = 8'd255; c.green = 8'd0; c.blue = 8'(down); end
      endcase
    end
    c.rgb565 = {c.red[7:3], c.green[7:2], c.blue[7:3]};
    return c;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each strobed result with the oldest pending request
  always @(posedge clk) begin : result_check
    pixel_color_t want;
    if (rst_n && out_valid) begin
      if (pending_colors.size() == 0) begin
        $error("result strobed with no request pending");
        mismatch_count++;
      end else begin
        want = pending_colors.pop_front();
        check_field("red_level", want.red, out_red_level);
        check_field("green_level", want.green, out_green_level);
        check_field("blue_level", want.blue, out_blue_level);
        check_field("packed_565", want.rgb565, out_packed_565);
      end
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Issue one request; hold start high so back-to-back requests need no toggle
  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] t);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    in_time_phase <= t;
    do @(posedge clk); while (busy);
    pending_colors.push_back(plasma_color(x, y, t));
  endtask

  // Drop start and wait until every pending result is back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (OUT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_rate(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_X_RATE:    x_rate = val;
      CFG_Y_RATE:    y_rate = val;
      CFG_DIAG_RATE: diag_rate = val;
      default: ;
    endcase
  endtask

  task automatic set_rates(input logic [RATE_W-1:0] xr, input logic [RATE_W-1:0] yr,
                           input logic [RATE_W-1:0] dr);
    write_rate(CFG_X_RATE, xr);
    write_rate(CFG_Y_RATE, yr);
    write_rate(CFG_DIAG_RATE, dr);
  endtask

  task automatic send_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_pixel(12'($urandom_range(0, 479)), 12'($urandom_range(0, 271)),
                   12'($urandom_range(0, 4095)));
      end else begin
        send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)));
      end
    end
  endtask

  // Reset rates: time sweep at the origin hits every sector, pure red and
  // the quadrant edges; then corner and off-frame coordinates
  task automatic test_reset_corners();
    int unsigned sweep[$] = '{0, 128, 256, 512, 1024, 1536, 2048, 2304, 2560, 3072,
                              3584, 4095};
    sender_idles = 1'b0;
    foreach (sweep[i]) send_pixel(0, 0, 12'(sweep[i]));
    send_pixel(4095, 4095, 0);
    send_pixel(4095, 0, 2048);
    send_pixel(0, 4095, 1024);
    send_pixel(480, 272, 100);
    send_pixel(479, 271, 3000);
    send_pixel(4095, 4095, 4095);
    send_pixel(2048, 2048, 2048);
    send_pixel(1, 1, 1);
    wait_drained();
  endtask

  // Rates at their extremes
  task automatic test_rate_extremes();
    sender_idles = 1'b1;
    set_rates(12'd0, 12'd0, 12'd0);
    send_random_pixels(10);
    wait_drained();
    set_rates(12'd4095, 12'd4095, 12'd4095);
    send_random_pixels(10);
    wait_drained();
    set_rates(12'd0, 12'd4095, 12'd1);
    send_random_pixels(10);
    wait_drained();
  endtask

  // A write to the unused index must leave all rates alone
  task automatic test_unused_index();
    write_rate(CFG_UNUSED, 12'($urandom_range(0, 4095)));
    send_random_pixels(10);
    wait_drained();
  endtask

  // Random rates per phase, idle on and off, one full pause mid-phase
  task automatic test_random_rates();
    logic [RATE_W-1:0] r[3];
    for (int p = 0; p < PHASES; p++) begin
      foreach (r[i]) begin
        case ($urandom_range(0, 3))
          0: r[i] = 12'd0;
          1: r[i] = 12'd4095;
          default: r[i] = 12'($urandom_range(0, 4095));
        endcase
      end
      set_rates(r[0], r[1], r[2]);
      for (int b = 0; b < PHASE_PIXELS / 16; b++) begin
        sender_idles = 1'($urandom_range(0, 1));
        send_random_pixels(16);
        if (b == 1) begin
          wait_drained();
        end
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_corners();
    test_rate_extremes();
    test_unused_index();
    test_random_rates();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/ppg_pkg.sv
design/ppg_phase.sv
design/ppg_sine.sv
design/ppg_color.sv
design/plasma_pixel_generator.sv
verif/tb.sv
